// ===== sv/brgb_pkg.sv =====
package brgb_pkg;

  // configuration port
  localparam int CFG_DATA_W = 16;
  localparam int CFG_INDEX_W = 1;
  localparam int FRAME_WIDTH_W = 13;
  localparam int FRAME_HEIGHT_W = 16;
  localparam int ROW_W = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [FRAME_WIDTH_W-1:0] FRAME_WIDTH_RESET = 13'd1920;
  localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 16'd1080;

  // per-item control decided at acceptance, used once the line store read returns
  typedef struct packed {
    logic emit;      // item gives a pixel pair
    logic top_row;   // pair is a top-row pair (odd row arriving)
    logic wr_even;   // samples go to the even row store
    logic wr_odd;    // samples go to the odd row store
    logic eof;       // pair closes the frame
  } brgb_ctl_t;

endpackage

// ===== sv/brgb_ram.sv =====
module brgb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port; read returns old data on a collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/brgb_seq.sv =====
module brgb_seq import brgb_pkg::*; #(
  parameter int PAIR_DEPTH = 2048,
  parameter int ADDR_W = 11
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   accept,
  input  logic                   drain,
  output logic [ADDR_W-1:0]      rd_addr,
  output brgb_ctl_t              ctl
);

  localparam int PAIRS_W = ADDR_W + 1;
  localparam logic [15:0] DEPTH16 = 16'(PAIR_DEPTH);

  logic [FRAME_WIDTH_W-1:0]  frame_width;
  logic [FRAME_HEIGHT_W-1:0] frame_height;
  logic [ADDR_W-1:0]         pair_column, pair_column_next;
  logic [ROW_W-1:0]          row_index, row_index_next;

  logic [15:0]        half_width;
  logic [15:0]        pairs16;
  logic [PAIRS_W-1:0] pairs;
  logic [PAIRS_W-1:0] col_ext;
  logic [PAIRS_W-1:0] col_c;
  logic               last_col;
  logic [ROW_W-1:0]   rows;
  logic               drain_row;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FRAME_WIDTH_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FRAME_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // row geometry: pairs per row clamped to 1..depth, rows rounded down to even, min 2
  always_comb begin
    half_width = {4'b0, frame_width[FRAME_WIDTH_W-1:1]};
    if (half_width == 16'd0) begin
      pairs16 = 16'd1;
    end else if (half_width > DEPTH16) begin
      pairs16 = DEPTH16;
    end else begin
      pairs16 = half_width;
    end
    pairs = pairs16[PAIRS_W-1:0];

    col_ext  = {1'b0, pair_column};
    col_c    = (col_ext >= pairs) ? (pairs - 1'b1) : col_ext;
    last_col = (col_c == (pairs - 1'b1));
    rd_addr  = col_c[ADDR_W-1:0];

    if (frame_height[FRAME_HEIGHT_W-1:1] == '0) begin
      rows = 16'd2;
    end else begin
      rows = {frame_height[FRAME_HEIGHT_W-1:1], 1'b0};
    end
    drain_row = (row_index >= rows);
  end

  // decode the item and step the raster position
  always_comb begin
    ctl = '0;
    pair_column_next = pair_column;
    row_index_next   = row_index;
    if (drain_row) begin
      ctl.emit    = 1'b1;
      ctl.wr_even = !drain;
      ctl.eof     = last_col;
      if (last_col) begin
        pair_column_next = '0;
        row_index_next   = drain ? '0 : ROW_W'(1);
      end else begin
        pair_column_next = col_c[ADDR_W-1:0] + 1'b1;
      end
    end else if (!drain) begin
      if (!row_index[0]) begin
        ctl.emit    = (row_index != '0);
        ctl.wr_even = 1'b1;
      end else begin
        ctl.emit    = 1'b1;
        ctl.top_row = 1'b1;
        ctl.wr_odd  = 1'b1;
      end
      if (last_col) begin
        pair_column_next = '0;
        row_index_next   = row_index + 1'b1;
      end else begin
        pair_column_next = col_c[ADDR_W-1:0] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_column <= '0;
      row_index   <= '0;
    end else if (accept) begin
      pair_column <= pair_column_next;
      row_index   <= row_index_next;
    end
  end

  // column stays inside the row once the geometry is settled
  a_col_in_row: assert property (@(posedge clk) disable iff (rst)
    (accept && !cfg_we) |=> ({1'b0, pair_column} < pairs))
    else $error("pair column beyond row");

  // a drain-row item always gives a pair
  a_drain_emits: assert property (@(posedge clk) disable iff (rst)
    (accept && drain_row) |-> ctl.emit)
    else $error("drain row item without pair");

  // never both stores for one item
  a_one_store: assert property (@(posedge clk) disable iff (rst)
    !(ctl.wr_even && ctl.wr_odd))
    else $error("item written to both stores");

endmodule

// ===== sv/brgb_out.sv =====
module brgb_out import brgb_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  logic [SAMPLE_BITS-1:0] pix_red,
  input  logic [SAMPLE_BITS-1:0] pix_green,
  input  logic [SAMPLE_BITS-1:0] pix_blue,
  input  logic                   pix_eof,
  output logic                   free,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] red,
  output logic [SAMPLE_BITS-1:0] green,
  output logic [SAMPLE_BITS-1:0] blue,
  output logic                   last_of_pair,
  output logic                   end_of_frame
);

  logic valid;
  logic phase;
  logic eof_hold;

  // a new pair may load as the second pixel of the current one is taken
  assign free = !valid || (out_ready && phase);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      phase <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
      phase <= 1'b0;
    end else if (valid && out_ready) begin
      if (phase) begin
        valid <= 1'b0;
        phase <= 1'b0;
      end else begin
        phase <= 1'b1;
      end
    end
  end

  // both pixels of a pair share the colour
  always_ff @(posedge clk) begin
    if (load) begin
      red      <= pix_red;
      green    <= pix_green;
      blue     <= pix_blue;
      eof_hold <= pix_eof;
    end
  end

  assign out_valid    = valid;
  assign last_of_pair = phase;
  assign end_of_frame = phase && eof_hold;

  // a freshly loaded pair starts on its first pixel
  a_load_first: assert property (@(posedge clk) disable iff (rst)
    load |=> (out_valid && !last_of_pair))
    else $error("pair does not start on first pixel");

  // second pixel follows the first once taken
  a_second_follows: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_of_pair) |=> (out_valid && last_of_pair))
    else $error("second pixel of pair lost");

  // end of frame only on a shown second pixel
  a_eof_second: assert property (@(posedge clk) disable iff (rst)
    end_of_frame |-> (out_valid && last_of_pair))
    else $error("end of frame off the second pixel");

endmodule

// ===== sv/bayer_rggb_nearest_debayer.sv =====
// RGGB Bayer to RGB, nearest neighbour.
// Input channel (in_valid/in_ready): one item is a pair of horizontal Bayer samples in
// raster order, or, with drain set, an empty item. After the last row of a frame send one
// row of items (frame_width/2 of them) to flush the bottom row; items carrying samples
// there already start the next frame.
// Output channel (out_valid/out_ready): one RGB pixel per beat, two per emitting item,
// last_of_pair on the second, end_of_frame on the final pixel of the frame.
// Row 0 items and drain items inside a frame give no pixels.
// Configuration (cfg_we/cfg_index/cfg_data): frame_width, frame_height; write while idle.
// An accepted item waits in the read stage for its store read and then loads the output
// pair register, which raises out_valid. An emitting item holds the one-pixel output port
// for both of its pixels before the next pair loads; silent items go at one per cycle while
// no item ahead of them is stalled. Each item does one read of both line stores on
// acceptance; items carrying samples do one write as they leave the read stage; a write to
// the column read next is forwarded.
// When the receiver stalls, the output pair, one item waiting on its store read, and
// in_ready back up in that order. Reset clears position and handshakes and restores the
// default geometry; the line store contents are not cleared.
module bayer_rggb_nearest_debayer import brgb_pkg::*; #(
  parameter int MAX_WIDTH = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] sample_left,
  input  logic [SAMPLE_BITS-1:0] sample_right,
  input  logic                   drain,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] red,
  output logic [SAMPLE_BITS-1:0] green,
  output logic [SAMPLE_BITS-1:0] blue,
  output logic                   last_of_pair,
  output logic                   end_of_frame
);

  localparam int PAIR_DEPTH = MAX_WIDTH / 2;
  localparam int ADDR_W = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
  localparam int PAIR_W = 2 * SAMPLE_BITS;

  logic              accept;
  logic [ADDR_W-1:0] rd_addr;
  brgb_ctl_t         ctl;

  // item waiting on its store read
  logic                   s1_valid;
  brgb_ctl_t              s1_ctl;
  logic [ADDR_W-1:0]      s1_addr;
  logic [SAMPLE_BITS-1:0] s1_left;
  logic [SAMPLE_BITS-1:0] s1_right;
  logic                   s1_fwd_even;
  logic                   s1_fwd_odd;
  logic [PAIR_W-1:0]      fwd_data;
  logic                   s1_adv;

  logic [PAIR_W-1:0] even_q, odd_q;
  logic [PAIR_W-1:0] even_rd, odd_rd;
  logic [PAIR_W-1:0] wr_data;
  logic              even_we, odd_we;

  logic                   out_free;
  logic                   out_load;
  logic [SAMPLE_BITS-1:0] pix_red, pix_green, pix_blue;

  assign s1_adv   = s1_valid && (!s1_ctl.emit || out_free);
  assign in_ready = !s1_valid || s1_adv;
  assign accept   = in_valid && in_ready;

  brgb_seq #(
    .PAIR_DEPTH (PAIR_DEPTH),
    .ADDR_W     (ADDR_W)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .drain     (drain),
    .rd_addr   (rd_addr),
    .ctl       (ctl)
  );

  // line stores: right sample high, left sample low
  assign wr_data = {s1_right, s1_left};
  assign even_we = s1_adv && s1_ctl.wr_even;
  assign odd_we  = s1_adv && s1_ctl.wr_odd;

  brgb_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (PAIR_DEPTH)
  ) u_even_row_store (
    .clk   (clk),
    .we    (even_we),
    .waddr (s1_addr),
    .wdata (wr_data),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (even_q)
  );

  brgb_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (PAIR_DEPTH)
  ) u_odd_row_store (
    .clk   (clk),
    .we    (odd_we),
    .waddr (s1_addr),
    .wdata (wr_data),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (odd_q)
  );

  // hand-off to the read stage; flag a write landing on the entry being read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl      <= ctl;
      s1_addr     <= rd_addr;
      s1_left     <= sample_left;
      s1_right    <= sample_right;
      s1_fwd_even <= even_we && (s1_addr == rd_addr);
      s1_fwd_odd  <= odd_we && (s1_addr == rd_addr);
      fwd_data    <= wr_data;
    end
  end

  // pixel from the cell: top row takes G from the top-right, bottom row from bottom-left
  always_comb begin
    even_rd = s1_fwd_even ? fwd_data : even_q;
    odd_rd  = s1_fwd_odd ? fwd_data : odd_q;
    pix_red = even_rd[SAMPLE_BITS-1:0];
    if (s1_ctl.top_row) begin
      pix_green = even_rd[PAIR_W-1:SAMPLE_BITS];
      pix_blue  = s1_right;
    end else begin
      pix_green = odd_rd[SAMPLE_BITS-1:0];
      pix_blue  = odd_rd[PAIR_W-1:SAMPLE_BITS];
    end
  end

  assign out_load = s1_adv && s1_ctl.emit;

  brgb_out #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (out_load),
    .pix_red      (pix_red),
    .pix_green    (pix_green),
    .pix_blue     (pix_blue),
    .pix_eof      (s1_ctl.eof),
    .free         (out_free),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .last_of_pair (last_of_pair),
    .end_of_frame (end_of_frame)
  );

  // a stalled item keeps the next one out
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |-> !accept)
    else $error("item accepted over a stalled one");

  // a forwarded entry was written on the cycle it was read
  a_fwd_source: assert property (@(posedge clk) disable iff (rst)
    (accept && s1_valid && s1_adv && s1_ctl.wr_even && (s1_addr == rd_addr))
      |=> s1_fwd_even)
    else $error("even store collision not forwarded");

  // the store write happens once, as the item leaves
  a_single_write: assert property (@(posedge clk) disable iff (rst)
    (even_we || odd_we) |=> !(($past(s1_addr) == s1_addr) && s1_valid && !accept
      && $stable(s1_ctl) && (even_we || odd_we) && $past(s1_valid) && !$past(accept)))
    else $error("line store written twice for one item");

endmodule
